// ===== src/durs_pkg.sv =====
package durs_pkg;

  // field widths
  localparam int unsigned MS_W   = 10;
  localparam int unsigned US_W   = 16;
  localparam int unsigned MM_W   = 16;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned CIDX_W = 2;

  // request modes
  localparam logic [MODE_W-1:0] MODE_START   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TICK    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CAPTURE = 2'd2;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_ECHO_TIMEOUT    = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_TRIGGER_SPACING = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_INVALID_MM      = 2'd2;

  // configuration reset values
  localparam logic [MS_W-1:0] ECHO_TIMEOUT_RST    = 10'd40;
  localparam logic [MS_W-1:0] TRIGGER_SPACING_RST = 10'd60;
  localparam logic [MM_W-1:0] INVALID_MM_RST      = 16'hFFFF;

  // (w*10+29)/58 == (w*5+14)/29, done as multiply by ceil(2^24/29) then shift
  localparam int unsigned NUM_W     = 19;
  localparam int unsigned RECIP_W   = 20;
  localparam int unsigned RECIP_SH  = 24;
  localparam int unsigned PROD_W    = NUM_W + RECIP_W;
  localparam logic [NUM_W-1:0]   ROUND_ADD = 19'd14;
  localparam logic [RECIP_W-1:0] RECIP_29  = 20'd578525;

  // status handed from the sequencer to the distance stage
  typedef struct packed {
    logic            trigger_fire;
    logic            trigger_sensor;
    logic            complete;
    logic            right_valid;
    logic            back_valid;
    logic [US_W-1:0] right_width;
    logic [US_W-1:0] back_width;
  } status_t;

endpackage

// ===== src/dual_ultrasonic_ranging_sequencer_top.sv =====
// Dual ultrasonic ranging sequencer: measures the right sensor, then the back one.
// Input channel (in_valid / in_stall): one request per transfer, in_mode selects a
// start request, a 1 ms tick or an echo edge capture (in_sensor, in_edge_rising,
// in_capture_time). Every request gives exactly one result on the output channel
// (out_valid / out_stall): trigger event, completion, both valid flags and both
// distances in mm.
// Pipeline: input register, sequencer stage with status register, distance
// stage with result register; a request passes the input, status and result registers.
// Throughput is one request per cycle unless out_stall holds; the sequencer state
// update is combinational, and the mm conversion is one constant multiply at the end.
// Registers advance whenever the stage after them is empty or moving, so a
// stalled receiver fills the three stages before in_stall rises; nothing is lost.
// Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data) is always ready and
// should only be written while no request is in flight.
// Synchronous reset (rst_n low) empties the pipeline, returns the sequencer to
// idle with zero countdowns and clears the flags; config returns to 40 ms,
// 60 ms and marker 65535.
module dual_ultrasonic_ranging_sequencer_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [durs_pkg::MODE_W-1:0]  in_mode,
  input  logic                         in_sensor,
  input  logic                         in_edge_rising,
  input  logic [durs_pkg::US_W-1:0]    in_capture_time,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_trigger_fire,
  output logic                         out_trigger_sensor,
  output logic                         out_complete,
  output logic                         out_right_valid,
  output logic                         out_back_valid,
  output logic [durs_pkg::MM_W-1:0]    out_right_range,
  output logic [durs_pkg::MM_W-1:0]    out_back_mm,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [durs_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [durs_pkg::MM_W-1:0]    cfg_data
);

  logic [durs_pkg::MS_W-1:0] echo_timeout_r;
  logic [durs_pkg::MS_W-1:0] trigger_spacing_r;
  logic [durs_pkg::MM_W-1:0] invalid_mm_r;
  logic                      st_valid;
  logic                      st_ready;
  durs_pkg::status_t         st;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      echo_timeout_r    <= durs_pkg::ECHO_TIMEOUT_RST;
      trigger_spacing_r <= durs_pkg::TRIGGER_SPACING_RST;
      invalid_mm_r      <= durs_pkg::INVALID_MM_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        durs_pkg::CFG_ECHO_TIMEOUT:    echo_timeout_r    <= cfg_data[durs_pkg::MS_W-1:0];
        durs_pkg::CFG_TRIGGER_SPACING: trigger_spacing_r <= cfg_data[durs_pkg::MS_W-1:0];
        durs_pkg::CFG_INVALID_MM:      invalid_mm_r      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // sequencer
  durs_seq u_seq (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_mode            (in_mode),
    .in_sensor          (in_sensor),
    .in_edge_rising     (in_edge_rising),
    .in_capture_time    (in_capture_time),
    .echo_timeout_ms    (echo_timeout_r),
    .trigger_spacing_ms (trigger_spacing_r),
    .st_valid           (st_valid),
    .st                 (st),
    .st_ready           (st_ready)
  );

  // distance conversion and result register
  durs_dist u_dist (
    .clk                (clk),
    .rst_n              (rst_n),
    .st_valid           (st_valid),
    .st                 (st),
    .st_ready           (st_ready),
    .invalid_mm         (invalid_mm_r),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_trigger_fire   (out_trigger_fire),
    .out_trigger_sensor (out_trigger_sensor),
    .out_complete       (out_complete),
    .out_right_valid    (out_right_valid),
    .out_back_valid     (out_back_valid),
    .out_right_range    (out_right_range),
    .out_back_mm        (out_back_mm)
  );

  // input only backs up when every stage is full and the receiver stalls
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the pipeline can still move");

  // a trigger is only fired before the back echo has been measured
  a_fire_no_back: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_trigger_fire) |-> !out_back_valid)
    else $error("trigger fired with back measurement already valid");

  // pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

// ===== src/durs_seq.sv =====
module durs_seq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [durs_pkg::MODE_W-1:0]  in_mode,
  input  logic                         in_sensor,
  input  logic                         in_edge_rising,
  input  logic [durs_pkg::US_W-1:0]    in_capture_time,
  input  logic [durs_pkg::MS_W-1:0]    echo_timeout_ms,
  input  logic [durs_pkg::MS_W-1:0]    trigger_spacing_ms,
  output logic                         st_valid,
  output durs_pkg::status_t            st,
  input  logic                         st_ready
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TRIG_RIGHT,
    PH_WAIT_R_RISE,
    PH_WAIT_R_FALL,
    PH_TRIG_BACK,
    PH_WAIT_B_RISE,
    PH_WAIT_B_FALL,
    PH_DONE
  } phase_t;

  // input register
  logic                        s1_valid_r;
  logic [durs_pkg::MODE_W-1:0] s1_mode_r;
  logic                        s1_sensor_r;
  logic                        s1_rising_r;
  logic [durs_pkg::US_W-1:0]   s1_stamp_r;

  // sequencer state
  phase_t                      phase_r, phase_nxt;
  logic [durs_pkg::US_W-1:0]   rise_stamp_r, rise_stamp_nxt;
  logic [durs_pkg::US_W-1:0]   right_width_r, right_width_nxt;
  logic [durs_pkg::US_W-1:0]   back_width_r, back_width_nxt;
  logic [durs_pkg::MS_W-1:0]   echo_left_r, echo_left_nxt;
  logic [durs_pkg::MS_W-1:0]   spacing_left_r, spacing_left_nxt;
  logic                        right_flag_r, right_flag_nxt;
  logic                        back_flag_r, back_flag_nxt;
  logic                        fire;

  // status register
  logic                        st_valid_r;
  durs_pkg::status_t           st_r, st_nxt;

  logic s2_ready;
  logic s2_load;
  logic s1_ready;
  logic in_take;

  assign s2_ready = !st_valid_r || st_ready;
  assign s2_load  = s1_valid_r && s2_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_stall = !s1_ready;
  assign in_take  = in_valid && s1_ready;
  assign st_valid = st_valid_r;
  assign st       = st_r;

  // next state for the request in the input register
  always_comb begin
    phase_nxt        = phase_r;
    rise_stamp_nxt   = rise_stamp_r;
    right_width_nxt  = right_width_r;
    back_width_nxt   = back_width_r;
    echo_left_nxt    = echo_left_r;
    spacing_left_nxt = spacing_left_r;
    right_flag_nxt   = right_flag_r;
    back_flag_nxt    = back_flag_r;
    fire             = 1'b0;
    case (s1_mode_r)
      durs_pkg::MODE_START: begin
        if (phase_r == PH_IDLE || phase_r == PH_DONE) begin
          right_flag_nxt = 1'b0;
          back_flag_nxt  = 1'b0;
          phase_nxt      = PH_TRIG_RIGHT;
          if (spacing_left_r == '0) begin
            echo_left_nxt    = echo_timeout_ms;
            spacing_left_nxt = trigger_spacing_ms;
            phase_nxt        = PH_WAIT_R_RISE;
            fire             = 1'b1;
          end
        end
      end
      durs_pkg::MODE_TICK: begin
        // saturating countdowns
        if (echo_left_r != '0) begin
          echo_left_nxt = echo_left_r - 1'b1;
        end
        if (spacing_left_r != '0) begin
          spacing_left_nxt = spacing_left_r - 1'b1;
        end
        // pending trigger
        if (phase_r == PH_TRIG_RIGHT && spacing_left_nxt == '0) begin
          echo_left_nxt    = echo_timeout_ms;
          spacing_left_nxt = trigger_spacing_ms;
          phase_nxt        = PH_WAIT_R_RISE;
          fire             = 1'b1;
        end else if (phase_r == PH_TRIG_BACK && spacing_left_nxt == '0) begin
          echo_left_nxt    = echo_timeout_ms;
          spacing_left_nxt = trigger_spacing_ms;
          phase_nxt        = PH_WAIT_B_RISE;
          fire             = 1'b1;
        end
        // echo timeout
        if ((phase_nxt inside {PH_WAIT_R_RISE, PH_WAIT_R_FALL}) && echo_left_nxt == '0) begin
          phase_nxt = PH_TRIG_BACK;
        end else if ((phase_nxt inside {PH_WAIT_B_RISE, PH_WAIT_B_FALL}) &&
                     echo_left_nxt == '0) begin
          phase_nxt = PH_DONE;
        end
      end
      durs_pkg::MODE_CAPTURE: begin
        if (!s1_sensor_r) begin
          if (phase_r == PH_WAIT_R_RISE && s1_rising_r) begin
            rise_stamp_nxt = s1_stamp_r;
            phase_nxt      = PH_WAIT_R_FALL;
          end else if (phase_r == PH_WAIT_R_FALL && !s1_rising_r) begin
            right_width_nxt = s1_stamp_r - rise_stamp_r;
            right_flag_nxt  = 1'b1;
            phase_nxt       = PH_TRIG_BACK;
          end
        end else begin
          if (phase_r == PH_WAIT_B_RISE && s1_rising_r) begin
            rise_stamp_nxt = s1_stamp_r;
            phase_nxt      = PH_WAIT_B_FALL;
          end else if (phase_r == PH_WAIT_B_FALL && !s1_rising_r) begin
            back_width_nxt = s1_stamp_r - rise_stamp_r;
            back_flag_nxt  = 1'b1;
            phase_nxt      = PH_DONE;
          end
        end
      end
      default: begin
      end
    endcase

    // status seen after this request
    st_nxt.trigger_fire   = fire;
    st_nxt.trigger_sensor = phase_nxt inside {PH_TRIG_BACK, PH_WAIT_B_RISE, PH_WAIT_B_FALL};
    st_nxt.complete       = (phase_nxt == PH_DONE);
    st_nxt.right_valid    = right_flag_nxt;
    st_nxt.back_valid     = back_flag_nxt;
    st_nxt.right_width    = right_width_nxt;
    st_nxt.back_width     = back_width_nxt;
  end

  // input register, sequencer state and status register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      st_valid_r     <= 1'b0;
      phase_r        <= PH_IDLE;
      rise_stamp_r   <= '0;
      right_width_r  <= '0;
      back_width_r   <= '0;
      echo_left_r    <= '0;
      spacing_left_r <= '0;
      right_flag_r   <= 1'b0;
      back_flag_r    <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s2_ready) begin
        st_valid_r <= s1_valid_r;
      end
      if (s2_load) begin
        phase_r        <= phase_nxt;
        rise_stamp_r   <= rise_stamp_nxt;
        right_width_r  <= right_width_nxt;
        back_width_r   <= back_width_nxt;
        echo_left_r    <= echo_left_nxt;
        spacing_left_r <= spacing_left_nxt;
        right_flag_r   <= right_flag_nxt;
        back_flag_r    <= back_flag_nxt;
      end
    end
    if (in_take) begin
      s1_mode_r   <= in_mode;
      s1_sensor_r <= in_sensor;
      s1_rising_r <= in_edge_rising;
      s1_stamp_r  <= in_capture_time;
    end
    if (s2_load) begin
      st_r <= st_nxt;
    end
  end

endmodule

// ===== src/durs_dist.sv =====
module durs_dist (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       st_valid,
  input  durs_pkg::status_t          st,
  output logic                       st_ready,
  input  logic [durs_pkg::MM_W-1:0]  invalid_mm,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_trigger_fire,
  output logic                       out_trigger_sensor,
  output logic                       out_complete,
  output logic                       out_right_valid,
  output logic                       out_back_valid,
  output logic [durs_pkg::MM_W-1:0]  out_right_range,
  output logic [durs_pkg::MM_W-1:0]  out_back_mm
);

  logic                       out_valid_r;
  durs_pkg::status_t          flags_r;
  logic [durs_pkg::MM_W-1:0]  right_range_r, right_range_nxt;
  logic [durs_pkg::MM_W-1:0]  back_mm_r, back_mm_nxt;
  logic                       load;

  // echo width in us to saturated millimetres, or the marker when not measured
  function automatic logic [durs_pkg::MM_W-1:0] to_mm(
    input logic                      meas_ok,
    input logic [durs_pkg::US_W-1:0] width,
    input logic [durs_pkg::MM_W-1:0] marker
  );
    logic [durs_pkg::NUM_W-1:0]  num;
    logic [durs_pkg::PROD_W-1:0] prod;
    logic [durs_pkg::MM_W-1:0]   scaled;
    num    = durs_pkg::NUM_W'({width, 2'b00}) + durs_pkg::NUM_W'(width) + durs_pkg::ROUND_ADD;
    prod   = durs_pkg::PROD_W'(num) * durs_pkg::PROD_W'(durs_pkg::RECIP_29);
    scaled = durs_pkg::MM_W'(prod >> durs_pkg::RECIP_SH);
    if (!meas_ok) begin
      return marker;
    end else if (scaled < marker) begin
      return scaled;
    end else begin
      return marker - 1'b1;
    end
  endfunction

  assign st_ready = !out_valid_r || !out_stall;
  assign load     = st_valid && st_ready;

  always_comb begin
    right_range_nxt = to_mm(st.right_valid, st.right_width, invalid_mm);
    back_mm_nxt     = to_mm(st.back_valid, st.back_width, invalid_mm);
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (st_ready) begin
      out_valid_r <= st_valid;
    end
    if (load) begin
      flags_r       <= st;
      right_range_r <= right_range_nxt;
      back_mm_r     <= back_mm_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_trigger_fire   = flags_r.trigger_fire;
  assign out_trigger_sensor = flags_r.trigger_sensor;
  assign out_complete       = flags_r.complete;
  assign out_right_valid    = flags_r.right_valid;
  assign out_back_valid     = flags_r.back_valid;
  assign out_right_range    = right_range_r;
  assign out_back_mm        = back_mm_r;

endmodule
